// ===== rtl/core/one_bone_ik_tip_placement_macros.svh =====
// assertion macros shared by the tip placement rtl
// needs clk_i and rst_ni in the scope of each use
`ifndef ONE_BONE_IK_TIP_PLACEMENT_MACROS_SVH
`define ONE_BONE_IK_TIP_PLACEMENT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define OBTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define OBTP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define OBTP_ASSERT(lbl, prop, msg)
`define OBTP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/obtp_pkg.sv =====
// shared constants for the one-bone tip placement block
// no dependencies
package obtp_pkg;

  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned Axes          = 3;

  // extra fraction bits of the normalised length
  function automatic int unsigned norm_extra(input int unsigned w);
    return 62 - w;
  endfunction

endpackage

// ===== rtl/core/one_bone_ik_tip_placement.sv =====
// One-bone tip placement: tip = base + dir * bone_length / |dir|, saturated.
// Throughput one item per cycle; busy never rises since the back end never stalls.
// The pipeline depth is set mostly by the 64-stage square root and the
// COORD_WIDTH-stage dividers.
// Reset clears all valid flags and the queue; no clearing pass is needed.
// Depends on obtp_pkg, obtp_front, obtp_queue, obtp_sqrt, obtp_div and the macros header.
`include "one_bone_ik_tip_placement_macros.svh"
module one_bone_ik_tip_placement #(
  parameter int unsigned COORD_WIDTH = obtp_pkg::CoordWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] base_x_i,
  input  logic [COORD_WIDTH-1:0] base_y_i,
  input  logic [COORD_WIDTH-1:0] base_z_i,
  input  logic [COORD_WIDTH-1:0] target_x_i,
  input  logic [COORD_WIDTH-1:0] target_y_i,
  input  logic [COORD_WIDTH-1:0] target_z_i,
  input  logic [COORD_WIDTH-2:0] bone_length_i,
  output logic                   valid_o,
  output logic [COORD_WIDTH-1:0] tip_x_o,
  output logic [COORD_WIDTH-1:0] tip_y_o,
  output logic [COORD_WIDTH-1:0] tip_z_o,
  output logic                   degenerate_o,
  output logic                   clipped_o
);
  import obtp_pkg::*;

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned NE   = norm_extra(COORD_WIDTH);
  localparam int unsigned MW   = W + 1;
  localparam int unsigned SQW  = 2 * MW;
  localparam int unsigned SW   = SQW + 2;
  localparam int unsigned RADW = SW + 2 * NE;
  localparam int unsigned ROOTW = RADW / 2;
  localparam int unsigned PW   = MW + W - 1;
  localparam int unsigned NUMW = PW + NE + 1;
  localparam int unsigned QDW  = (W - 1) + 1 + Axes + Axes * MW + Axes * W;
  localparam int unsigned SQSB = Axes * PW + Axes * W + Axes + 1;
  localparam int unsigned DSB  = W + 2;

  // front end
  logic                   f_valid, q_full, q_empty;
  logic [Axes-1:0][W-1:0] f_base;
  logic [Axes-1:0][MW-1:0] f_mag;
  logic [Axes-1:0]        f_neg;
  logic                   f_degen;
  logic [W-2:0]           f_len;
  logic [QDW-1:0]         q_wdata, q_rdata;

  obtp_front #(.W(W)) u_front (
    .clk_i, .rst_ni,
    .start_i(start), .full_i(q_full),
    .base_x_i, .base_y_i, .base_z_i,
    .target_x_i, .target_y_i, .target_z_i,
    .bone_length_i,
    .valid_o(f_valid), .base_o(f_base), .mag_o(f_mag),
    .neg_o(f_neg), .degen_o(f_degen), .len_o(f_len)
  );

  assign busy    = q_full;
  assign q_wdata = {f_len, f_degen, f_neg, f_mag, f_base};

  obtp_queue #(.DW(QDW)) u_queue (
    .clk_i, .rst_ni,
    .push_i(f_valid), .data_i(q_wdata),
    .pop_i(~q_empty),
    .empty_o(q_empty), .full_o(q_full), .data_o(q_rdata)
  );

  // unpack the queue head
  logic [Axes-1:0][W-1:0]  h_base;
  logic [Axes-1:0][MW-1:0] h_mag;
  logic [Axes-1:0]         h_neg;
  logic                    h_degen;
  logic [W-2:0]            h_len;

  assign {h_len, h_degen, h_neg, h_mag, h_base} = q_rdata;

  // stage a: squares and scaled products
  logic                     a_vld_q;
  logic [Axes-1:0][SQW-1:0] a_sq_q;
  logic [Axes-1:0][PW-1:0]  a_p_q;
  logic [Axes-1:0][W-1:0]   a_base_q;
  logic [Axes-1:0]          a_neg_q;
  logic                     a_degen_q;

  // stage b: sum of squares
  logic                     b_vld_q;
  logic [SW-1:0]            b_s_q;
  logic [Axes-1:0][PW-1:0]  b_p_q;
  logic [Axes-1:0][W-1:0]   b_base_q;
  logic [Axes-1:0]          b_neg_q;
  logic                     b_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= ~q_empty;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Axes; i++) begin
      a_sq_q[i] <= h_mag[i] * h_mag[i];
      a_p_q[i]  <= h_mag[i] * h_len;
    end
    a_base_q  <= h_base;
    a_neg_q   <= h_neg;
    a_degen_q <= h_degen;
    b_s_q     <= SW'(a_sq_q[0]) + SW'(a_sq_q[1]) + SW'(a_sq_q[2]);
    b_p_q     <= a_p_q;
    b_base_q  <= a_base_q;
    b_neg_q   <= a_neg_q;
    b_degen_q <= a_degen_q;
  end

  // length of the direction with extra fraction bits
  logic                     s_vld;
  logic [ROOTW-1:0]         s_root;
  logic [SQSB-1:0]          s_sb;
  logic [Axes-1:0][PW-1:0]  s_p;
  logic [Axes-1:0][W-1:0]   s_base;
  logic [Axes-1:0]          s_neg;
  logic                     s_degen;

  obtp_sqrt #(.RADW(RADW), .SBW(SQSB)) u_sqrt (
    .clk_i, .rst_ni,
    .valid_i(b_vld_q),
    .rad_i({b_s_q, {(2 * NE){1'b0}}}),
    .sb_i({b_degen_q, b_neg_q, b_base_q, b_p_q}),
    .valid_o(s_vld), .root_o(s_root), .sb_o(s_sb)
  );

  assign {s_degen, s_neg, s_base, s_p} = s_sb;

  // stage c: rounded numerators; a zero length only comes with a zero direction
  logic                      c_vld_q;
  logic [Axes-1:0][NUMW-1:0] c_num_q;
  logic [ROOTW-1:0]          c_den_q;
  logic [Axes-1:0][W-1:0]    c_base_q;
  logic [Axes-1:0]           c_neg_q;
  logic                      c_degen_q;
  logic [ROOTW-1:0]          den;

  assign den = (s_root == '0) ? ROOTW'(1) : s_root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= s_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Axes; i++) begin
      c_num_q[i] <= NUMW'({s_p[i], {NE{1'b0}}}) + NUMW'(den >> 1);
    end
    c_den_q   <= den;
    c_base_q  <= s_base;
    c_neg_q   <= s_neg;
    c_degen_q <= s_degen;
  end

  // one divider per axis
  logic [Axes-1:0]         d_vld;
  logic [Axes-1:0][W-1:0]  d_quot;
  logic [Axes-1:0][DSB-1:0] d_sb;

  for (genvar i = 0; i < Axes; i++) begin : g_div
    obtp_div #(.NUMW(NUMW), .DENW(ROOTW), .QW(W), .SBW(DSB)) u_div (
      .clk_i, .rst_ni,
      .valid_i(c_vld_q),
      .num_i(c_num_q[i]),
      .den_i(c_den_q),
      .sb_i({c_degen_q, c_neg_q[i], c_base_q[i]}),
      .valid_o(d_vld[i]), .quot_o(d_quot[i]), .sb_o(d_sb[i])
    );
  end

  // add offsets and saturate
  logic [Axes-1:0][W-1:0] tip;
  logic [Axes-1:0]        clip;

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      logic [W+1:0] v, off;
      off = {2'b00, d_quot[i]};
      v   = {{2{d_sb[i][W-1]}}, d_sb[i][W-1:0]} + (d_sb[i][W] ? (~off + 1'b1) : off);
      if (!v[W+1] && (v[W:W-1] != 2'b00)) begin
        tip[i]  = {1'b0, {(W-1){1'b1}}};
        clip[i] = 1'b1;
      end else if (v[W+1] && (v[W:W-1] != 2'b11)) begin
        tip[i]  = {1'b1, {(W-1){1'b0}}};
        clip[i] = 1'b1;
      end else begin
        tip[i]  = v[W-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  // result register
  logic                   o_vld_q, o_degen_q, o_clip_q;
  logic [Axes-1:0][W-1:0] o_tip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else begin
      o_vld_q <= d_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    o_tip_q   <= tip;
    o_degen_q <= d_sb[0][W+1];
    o_clip_q  <= |clip;
  end

  assign valid_o      = o_vld_q;
  assign tip_x_o      = o_tip_q[0];
  assign tip_y_o      = o_tip_q[1];
  assign tip_z_o      = o_tip_q[2];
  assign degenerate_o = o_degen_q;
  assign clipped_o    = o_clip_q;

  `OBTP_ASSERT(a_degen_no_clip, valid_o |-> !(degenerate_o && clipped_o), "degenerate item clipped")
  `OBTP_ASSERT(a_lanes_aligned, (d_vld[0] == d_vld[1]) && (d_vld[1] == d_vld[2]), "divider lanes out of step")
  `OBTP_ASSERT(a_never_busy, !busy, "queue failed to drain")
  `OBTP_ASSERT_RST(a_reset_quiet, !rst_ni |-> !valid_o, "result during reset")

endmodule

// ===== rtl/core/obtp_front.sv =====
// front end: takes an item, forms direction magnitudes and signs, flags a zero direction
// depends on obtp_pkg
module obtp_front #(
  parameter int unsigned W = obtp_pkg::CoordWidthDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                full_i,
  input  logic [W-1:0]                        base_x_i,
  input  logic [W-1:0]                        base_y_i,
  input  logic [W-1:0]                        base_z_i,
  input  logic [W-1:0]                        target_x_i,
  input  logic [W-1:0]                        target_y_i,
  input  logic [W-1:0]                        target_z_i,
  input  logic [W-2:0]                        bone_length_i,
  output logic                                valid_o,
  output logic [obtp_pkg::Axes-1:0][W-1:0]    base_o,
  output logic [obtp_pkg::Axes-1:0][W:0]      mag_o,
  output logic [obtp_pkg::Axes-1:0]           neg_o,
  output logic                                degen_o,
  output logic [W-2:0]                        len_o
);
  import obtp_pkg::*;

  logic [Axes-1:0][W-1:0] b, t;
  logic [Axes-1:0][W:0]   d, mag;
  logic [Axes-1:0]        neg;
  logic                   accept;
  logic                   valid_q;
  logic [Axes-1:0][W-1:0] base_q;
  logic [Axes-1:0][W:0]   mag_q;
  logic [Axes-1:0]        neg_q;
  logic                   degen_q;
  logic [W-2:0]           len_q;

  assign b      = {base_z_i, base_y_i, base_x_i};
  assign t      = {target_z_i, target_y_i, target_x_i};
  assign accept = start_i & ~full_i;

  // signed difference and its magnitude per axis
  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      d[i]   = {t[i][W-1], t[i]} - {b[i][W-1], b[i]};
      neg[i] = d[i][W];
      mag[i] = neg[i] ? (~d[i] + 1'b1) : d[i];
    end
  end

  // item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      base_q  <= b;
      mag_q   <= mag;
      neg_q   <= neg;
      degen_q <= (d == '0);
      len_q   <= bone_length_i;
    end
  end

  assign valid_o = valid_q;
  assign base_o  = base_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;
  assign degen_o = degen_q;
  assign len_o   = len_q;

endmodule

// ===== rtl/core/obtp_queue.sv =====
// two-entry item queue between front and back end
// depends on the macros header
`include "one_bone_ik_tip_placement_macros.svh"
module obtp_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  input  logic          pop_i,
  output logic          empty_o,
  output logic          full_o,
  output logic [DW-1:0] data_o
);
  localparam int unsigned Depth = 2;

  logic [DW-1:0] mem_q [Depth];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'(Depth));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  `OBTP_ASSERT(a_q_no_overflow, full_o |-> !push_i, "item pushed into full queue")
  `OBTP_ASSERT(a_q_no_underflow, pop_i |-> !empty_o, "item popped from empty queue")
  `OBTP_ASSERT(a_q_count_range, cnt_q != 2'd3, "queue count out of range")

endmodule

// ===== rtl/core/obtp_sqrt.sv =====
// pipelined integer square root, one root bit per stage, with a sideband
// no dependencies
module obtp_sqrt #(
  parameter int unsigned RADW = 128,
  parameter int unsigned SBW  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [RADW-1:0]     rad_i,
  input  logic [SBW-1:0]      sb_i,
  output logic                valid_o,
  output logic [RADW/2-1:0]   root_o,
  output logic [SBW-1:0]      sb_o
);
  localparam int unsigned RootW = RADW / 2;
  localparam int unsigned RemW  = RootW + 2;

  logic                vld_q  [RootW+1];
  logic [RADW-1:0]     rad_q  [RootW+1];
  logic [RemW-1:0]     rem_q  [RootW+1];
  logic [RootW-1:0]    root_q [RootW+1];
  logic [SBW-1:0]      sb_q   [RootW+1];

  assign vld_q[0]  = valid_i;
  assign rad_q[0]  = rad_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign sb_q[0]   = sb_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW+1:0] cur, trial, diff;
    logic            ge;

    // trial subtract of (root*4 + 1)
    always_comb begin
      cur   = {rem_q[k], rad_q[k][RADW-1 -: 2]};
      trial = {2'b00, root_q[k], 2'b01};
      diff  = cur - trial;
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k+1]  <= {rad_q[k][RADW-3:0], 2'b00};
      rem_q[k+1]  <= ge ? diff[RemW-1:0] : cur[RemW-1:0];
      root_q[k+1] <= {root_q[k][RootW-2:0], ge};
      sb_q[k+1]   <= sb_q[k];
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = root_q[RootW];
  assign sb_o    = sb_q[RootW];

endmodule

// ===== rtl/core/obtp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with a sideband
// no dependencies
module obtp_div #(
  parameter int unsigned NUMW = 95,
  parameter int unsigned DENW = 64,
  parameter int unsigned QW   = 32,
  parameter int unsigned SBW  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUMW-1:0]  num_i,
  input  logic [DENW-1:0]  den_i,
  input  logic [SBW-1:0]   sb_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o,
  output logic [SBW-1:0]   sb_o
);
  logic              vld_q [QW+1];
  logic [DENW-1:0]   rem_q [QW+1];
  logic [QW-1:0]     lo_q  [QW+1];
  logic [QW-1:0]     q_q   [QW+1];
  logic [DENW-1:0]   den_q [QW+1];
  logic [SBW-1:0]    sb_q  [QW+1];

  // upper part of the numerator is already below the divisor
  assign vld_q[0] = valid_i;
  assign rem_q[0] = DENW'(num_i[NUMW-1:QW]);
  assign lo_q[0]  = num_i[QW-1:0];
  assign q_q[0]   = '0;
  assign den_q[0] = den_i;
  assign sb_q[0]  = sb_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DENW:0] cur, diff;
    logic          ge;

    always_comb begin
      cur  = {rem_q[k], lo_q[k][QW-1]};
      diff = cur - {1'b0, den_q[k]};
      ge   = (cur >= {1'b0, den_q[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? diff[DENW-1:0] : cur[DENW-1:0];
      lo_q[k+1]  <= {lo_q[k][QW-2:0], 1'b0};
      q_q[k+1]   <= {q_q[k][QW-2:0], ge};
      den_q[k+1] <= den_q[k];
      sb_q[k+1]  <= sb_q[k];
    end
  end

  assign valid_o = vld_q[QW];
  assign quot_o  = q_q[QW];
  assign sb_o    = sb_q[QW];

endmodule

// ===== tb/sv/one_bone_ik_tip_placement_tb.sv =====
// testbench for the one-bone tip placement block: directed and random poses
// checked against a bit-exact predictor held in a small scoreboard class
// depends on obtp_pkg and one_bone_ik_tip_placement
module one_bone_ik_tip_placement_tb;

  localparam int unsigned CW = obtp_pkg::CoordWidthDef;
  localparam int unsigned NormExtra = 62 - CW;
  localparam int unsigned Latency = CW + 69;
  localparam int unsigned RandomItems = 1100;

  typedef logic [CW-1:0] coord_t;
  typedef logic [CW-2:0] length_t;

  typedef struct packed {
    coord_t  base_x, base_y, base_z;
    coord_t  target_x, target_y, target_z;
    length_t bone_length;
  } pose_t;

  typedef struct packed {
    coord_t tip_x, tip_y, tip_z;
    logic   degenerate, clipped;
  } tip_t;

  // expected tips in accept order, checked against each strobed result
  class tip_board;
    tip_t expected_tips[$];
    int   errors;

    // floor of the square root of a 128-bit value
    function logic [127:0] root128(logic [127:0] num);
      logic [127:0] res, bitv;
      res = '0;
      bitv = 128'd1 << 126;
      while (bitv != 0 && bitv > num) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (num >= res + bitv) begin
          num = num - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function tip_t place_tip(pose_t p);
      longint base [3];
      longint delta [3];
      longint v, hi_lim, lo_lim;
      logic [127:0] mag [3];
      logic [127:0] sum, len, num, off;
      tip_t r;
      coord_t tips [3];
      base[0] = longint'($signed(p.base_x));
      base[1] = longint'($signed(p.base_y));
      base[2] = longint'($signed(p.base_z));
      delta[0] = longint'($signed(p.target_x)) - base[0];
      delta[1] = longint'($signed(p.target_y)) - base[1];
      delta[2] = longint'($signed(p.target_z)) - base[2];
      hi_lim = (longint'(1) <<< (CW - 1)) - 1;
      lo_lim = -hi_lim - 1;
      r = '0;
      // target on the base: hand back the base
      if (delta[0] == 0 && delta[1] == 0 && delta[2] == 0) begin
        r.tip_x = p.base_x;
        r.tip_y = p.base_y;
        r.tip_z = p.base_z;
        r.degenerate = 1'b1;
        return r;
      end
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = 128'(delta[i] < 0 ? -delta[i] : delta[i]);
        sum = sum + mag[i] * mag[i];
      end
      len = root128(sum << (2 * NormExtra));
      for (int i = 0; i < 3; i++) begin
        num = ((mag[i] * 128'(p.bone_length)) << NormExtra) + (len >> 1);
        off = num / len;
        v = base[i] + (delta[i] < 0 ? -longint'(off[63:0]) : longint'(off[63:0]));
        // saturate to the coordinate range
        if (v > hi_lim) begin
          v = hi_lim;
          r.clipped = 1'b1;
        end
        if (v < lo_lim) begin
          v = lo_lim;
          r.clipped = 1'b1;
        end
        tips[i] = coord_t'(v);
      end
      r.tip_x = tips[0];
      r.tip_y = tips[1];
      r.tip_z = tips[2];
      return r;
    endfunction

    function void note_item(pose_t p);
      expected_tips.push_back(place_tip(p));
    endfunction

    function void check_result(tip_t got);
      tip_t want;
      if (expected_tips.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = expected_tips.pop_front();
      if (got.tip_x !== want.tip_x)
        $display("%0t: tip_x expected %h actual %h", $time, want.tip_x, got.tip_x);
      if (got.tip_y !== want.tip_y)
        $display("%0t: tip_y expected %h actual %h", $time, want.tip_y, got.tip_y);
      if (got.tip_z !== want.tip_z)
        $display("%0t: tip_z expected %h actual %h", $time, want.tip_z, got.tip_z);
      if (got.degenerate !== want.degenerate)
        $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                 got.degenerate);
      if (got.clipped !== want.clipped)
        $display("%0t: clipped expected %b actual %b", $time, want.clipped, got.clipped);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk_i, rst_ni, start, busy, valid_o, degenerate_o, clipped_o;
  coord_t base_x_i, base_y_i, base_z_i, target_x_i, target_y_i, target_z_i;
  coord_t tip_x_o, tip_y_o, tip_z_o;
  length_t bone_length_i;
  bit idle_on;

  tip_board board = new();

  one_bone_ik_tip_placement i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .base_x_i, .base_y_i, .base_z_i,
    .target_x_i, .target_y_i, .target_z_i,
    .bone_length_i,
    .valid_o, .tip_x_o, .tip_y_o, .tip_z_o, .degenerate_o, .clipped_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o)
      board.check_result({tip_x_o, tip_y_o, tip_z_o, degenerate_o, clipped_o});
  end

  // present one item, hold it until accepted, with random gaps before it
  task automatic send_pose(pose_t p);
    @(negedge clk_i);
    if (idle_on && $urandom_range(99) < 30) begin
      start = 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk_i);
    end
    {base_x_i, base_y_i, base_z_i, target_x_i, target_y_i, target_z_i, bone_length_i} = p;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_item(p);
  endtask

  function automatic pose_t make_pose(coord_t bx, coord_t by, coord_t bz, coord_t tx,
                                      coord_t ty, coord_t tz, length_t l);
    return {bx, by, bz, tx, ty, tz, l};
  endfunction

  // random coordinate near a given point, within spread either side
  function automatic coord_t near(coord_t c, int spread);
    return c + coord_t'($signed($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    int kind;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, length_t'($urandom)};
    kind = $urandom_range(99);
    if (kind < 10) begin
      // target on the base
      p.target_x = p.base_x;
      p.target_y = p.base_y;
      p.target_z = p.base_z;
    end else if (kind < 45) begin
      // short direction, small bone
      p.target_x = near(p.base_x, 1 << $urandom_range(20));
      p.target_y = near(p.base_y, 1 << $urandom_range(20));
      p.target_z = near(p.base_z, 1 << $urandom_range(20));
      p.bone_length = length_t'($urandom_range(1 << $urandom_range(30)));
    end else if (kind < 55) begin
      // axis-aligned direction
      p.target_y = p.base_y;
      p.target_z = p.base_z;
    end else if (kind < 62) begin
      p.bone_length = '0;
    end
    return p;
  endfunction

  localparam coord_t CMax = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMin = {1'b1, {(CW-1){1'b0}}};
  localparam length_t LMax = '1;

  initial begin
    start = 1'b0;
    idle_on = 1'b1;
    {base_x_i, base_y_i, base_z_i, target_x_i, target_y_i, target_z_i, bone_length_i} = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: degenerate, zero length, extremes and saturation
    send_pose(make_pose(0, 0, 0, 0, 0, 0, 0));
    send_pose(make_pose(CMax, CMin, 5, CMax, CMin, 5, LMax));
    send_pose(make_pose(100, 200, 300, 500, -7, 9, 0));
    send_pose(make_pose(0, 0, 0, 32'h10000, 0, 0, 31'h20000));
    send_pose(make_pose(0, 0, 0, 0, -32'h10000, 0, 31'h8000));
    send_pose(make_pose(0, 0, 0, 0, 0, 3, 31'h3));
    send_pose(make_pose(CMin, CMin, CMin, CMax, CMax, CMax, LMax));
    send_pose(make_pose(CMax, CMax, CMax, CMin, CMin, CMin, LMax));
    send_pose(make_pose(CMax, 0, 0, CMax, 0, 1, LMax));
    send_pose(make_pose(CMax - 10, 0, 0, CMax, 0, 0, LMax));
    send_pose(make_pose(CMin + 10, 0, 0, CMin, 0, 0, LMax));
    send_pose(make_pose(0, 0, 0, 1, 1, 1, 31'h1));
    send_pose(make_pose(0, 0, 0, 1, 1, 1, LMax));
    send_pose(make_pose(-1, -1, -1, 1, 1, 1, 31'h7));
    send_pose(make_pose(CMax, CMax, CMax, CMax, CMax, CMax, LMax));
    send_pose(make_pose(CMin, CMin, CMin, CMin, CMin, CMin, 0));
    send_pose(make_pose(CMin, CMax, CMin, CMax, CMin, CMax, 1));

    // random poses, with a stretch of back-to-back items in the middle
    for (int i = 0; i < RandomItems; i++) begin
      idle_on = !(i >= 400 && i < 700);
      send_pose(random_pose());
    end
    @(negedge clk_i);
    start = 1'b0;

    while (board.expected_tips.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (board.errors == 0) $display("one_bone_ik_tip_placement test passed");
    else $display("one_bone_ik_tip_placement test failed");
    $finish;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("one_bone_ik_tip_placement test failed");
    $finish;
  end

endmodule
